@@ design/utc2ep_pkg.sv @@
// ----------------------------------------------------------------------------
// utc2ep_pkg
// shared widths, reciprocal constants and the month-start table for the
// utc calendar to epoch seconds converter
// ----------------------------------------------------------------------------
package utc2ep_pkg;

  localparam int YrsW   = 10;
  localparam int MonW   = 8;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int EpochW = 35;

  // division by 12 of an 8-bit month index: (n * 171) >> 11
  localparam int MonRecip = 171;
  localparam int MonShift = 11;
  localparam int MonProdW = 16;
  localparam int MonQW    = 5;

  // division by 100 of values up to 1044: (n * 5243) >> 19
  localparam int HunRecip = 5243;
  localparam int HunShift = 19;

  // years after 1900, including the month carry (0..1044)
  localparam int YearW = 11;

  // cumulative days before each month of a common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ design/utc_calendar_to_epoch_seconds_core.sv @@
// ----------------------------------------------------------------------------
// utc_calendar_to_epoch_seconds_core
// converts a broken-down utc time into seconds since the unix epoch
// ----------------------------------------------------------------------------
// path: an accepted item moves through the stage 1 to 6 registers to out_valid
// throughput: one item per cycle; the six stages all advance together
// and hold as a whole while a result sits stalled in the output register
// reset: synchronous, active low, clears every stage valid bit; payload
// registers are not reset
module utc_calendar_to_epoch_seconds_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [utc2ep_pkg::YrsW-1:0]       in_years_since_1900,
  input  logic [utc2ep_pkg::MonW-1:0]       in_month_index,
  input  logic [utc2ep_pkg::DayW-1:0]       in_day_of_month,
  input  logic [utc2ep_pkg::HourW-1:0]      in_hour_of_day,
  input  logic [utc2ep_pkg::MinW-1:0]       in_minute_of_hour,
  input  logic [utc2ep_pkg::SecW-1:0]       in_second_of_minute,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [utc2ep_pkg::EpochW-1:0]     out_epoch_seconds
);
  import utc2ep_pkg::*;

  // days before 1970 in the year-times-365 term, the 1968 leap offset
  // folded into (y + 32) / 4 - 25, and the day-of-month base of one
  localparam int DayBias = 25550 + 25 + 1;
  localparam int DaysW   = 21;  // signed day count
  localparam int T1W     = 26;  // signed hours
  localparam int T2W     = 32;  // signed minutes
  localparam int T3W     = 38;  // signed seconds

  // whole pipe moves unless the result register holds a stalled item
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // stage 1: split month index into year carry and month of year
  // --------------------------------------------------------------------------
  logic [MonProdW-1:0] mon_prod;
  logic [MonQW-1:0]    mq_nxt;
  logic [7:0]          mq12;
  logic [3:0]          mrem_nxt;

  assign mon_prod = MonProdW'(in_month_index) * MonProdW'(MonRecip);
  assign mq_nxt   = mon_prod[MonShift +: MonQW];
  assign mq12     = 8'(mq_nxt) * 8'd12;
  assign mrem_nxt = 4'(in_month_index - mq12);

  logic               v1_r;
  logic [YrsW-1:0]    yrs1_r;
  logic [MonQW-1:0]   mq1_r;
  logic [3:0]         mrem1_r;
  logic [DayW-1:0]    day1_r;
  logic [HourW-1:0]   hour1_r;
  logic [MinW-1:0]    min1_r;
  logic [SecW-1:0]    sec1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yrs1_r  <= in_years_since_1900;
      mq1_r   <= mq_nxt;
      mrem1_r <= mrem_nxt;
      day1_r  <= in_day_of_month;
      hour1_r <= in_hour_of_day;
      min1_r  <= in_minute_of_hour;
      sec1_r  <= in_second_of_minute;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: full year offset y = year - 1900, century quotients
  // qa = y / 100, qb = (y + 300) / 400 = ((y + 300) >> 2) / 100
  // --------------------------------------------------------------------------
  logic [YearW-1:0] y_nxt;
  logic [YearW-1:0] v_s2;
  logic [23:0]      qa_prod;
  logic [21:0]      qb_prod;
  logic [3:0]       qa_nxt;
  logic [2:0]       qb_nxt;

  assign y_nxt   = YearW'(yrs1_r) + YearW'(mq1_r);
  assign v_s2    = y_nxt + YearW'(300);
  assign qa_prod = 24'(y_nxt) * 24'(HunRecip);
  assign qb_prod = 22'(v_s2[YearW-1:2]) * 22'(HunRecip);
  assign qa_nxt  = qa_prod[HunShift +: 4];
  assign qb_nxt  = qb_prod[HunShift +: 3];

  logic               v2_r;
  logic [YearW-1:0]   y2_r;
  logic [3:0]         qa2_r;
  logic [2:0]         qb2_r;
  logic [3:0]         mrem2_r;
  logic [DayW-1:0]    day2_r;
  logic [HourW-1:0]   hour2_r;
  logic [MinW-1:0]    min2_r;
  logic [SecW-1:0]    sec2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y2_r    <= y_nxt;
      qa2_r   <= qa_nxt;
      qb2_r   <= qb_nxt;
      mrem2_r <= mrem1_r;
      day2_r  <= day1_r;
      hour2_r <= hour1_r;
      min2_r  <= min1_r;
      sec2_r  <= sec1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: day count relative to 1970-01-01, may be negative
  // --------------------------------------------------------------------------
  logic [YearW-1:0] v_s3;
  logic [YearW-1:0] y32;
  logic [18:0]      y365;
  logic [YearW-1:0] qa100;
  logic [8:0]       qb100;
  logic             div4, div100, div400, leap_adj;
  logic signed [DaysW-1:0] days_nxt;

  assign v_s3   = y2_r + YearW'(300);
  assign y32    = y2_r + YearW'(32);
  assign y365   = 19'(y2_r) * 19'd365;
  assign qa100  = YearW'(qa2_r) * YearW'(100);
  assign qb100  = 9'(qb2_r) * 9'd100;
  // leap tests run on y since 1900 and 1600 are multiples of 4 and 400
  assign div4   = (y2_r[1:0] == 2'b00);
  assign div100 = (y2_r == qa100);
  assign div400 = (v_s3[1:0] == 2'b00) && (v_s3[YearW-1:2] == qb100);
  // leap day not yet reached in january and february
  assign leap_adj = div4 && (!div100 || div400) && (mrem2_r < 4'd2);

  always_comb begin
    days_nxt = $signed(DaysW'(y365))
             - $signed(DaysW'(DayBias))
             + $signed(DaysW'(month_start(mrem2_r)))
             + $signed(DaysW'(y32[YearW-1:2]))
             - $signed(DaysW'(qa2_r))
             + $signed(DaysW'(qb2_r))
             - $signed(DaysW'(leap_adj))
             + $signed(DaysW'(day2_r));
  end

  logic                    v3_r;
  logic signed [DaysW-1:0] days3_r;
  logic [HourW-1:0]        hour3_r;
  logic [MinW-1:0]         min3_r;
  logic [SecW-1:0]         sec3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      days3_r <= days_nxt;
      hour3_r <= hour2_r;
      min3_r  <= min2_r;
      sec3_r  <= sec2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: hours
  // --------------------------------------------------------------------------
  logic signed [T1W-1:0] days_ext;
  logic signed [T1W-1:0] t1_nxt;

  assign days_ext = {{(T1W-DaysW){days3_r[DaysW-1]}}, days3_r};
  assign t1_nxt   = days_ext * T1W'(24) + $signed(T1W'(hour3_r));

  logic                  v4_r;
  logic signed [T1W-1:0] t1_4_r;
  logic [MinW-1:0]       min4_r;
  logic [SecW-1:0]       sec4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_4_r <= t1_nxt;
      min4_r <= min3_r;
      sec4_r <= sec3_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: minutes
  // --------------------------------------------------------------------------
  logic signed [T2W-1:0] t1_ext;
  logic signed [T2W-1:0] t2_nxt;

  assign t1_ext = {{(T2W-T1W){t1_4_r[T1W-1]}}, t1_4_r};
  assign t2_nxt = t1_ext * T2W'(60) + $signed(T2W'(min4_r));

  logic                  v5_r;
  logic signed [T2W-1:0] t2_5_r;
  logic [SecW-1:0]       sec5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_5_r <= t2_nxt;
      sec5_r <= sec4_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: seconds, clamp instants before the epoch to zero, output register
  // --------------------------------------------------------------------------
  logic signed [T3W-1:0] t2_ext;
  logic signed [T3W-1:0] t3;
  logic [EpochW-1:0]     epoch_nxt;

  assign t2_ext    = {{(T3W-T2W){t2_5_r[T2W-1]}}, t2_5_r};
  assign t3        = t2_ext * T3W'(60) + $signed(T3W'(sec5_r));
  assign epoch_nxt = t3[T3W-1] ? '0 : t3[EpochW-1:0];

  logic              out_valid_r;
  logic [EpochW-1:0] epoch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      epoch_r <= epoch_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = epoch_r;

endmodule

@@ design/utc2ep_checker.sv @@
// ----------------------------------------------------------------------------
// utc2ep_checker
// port-level checks for the utc calendar to epoch seconds converter
// ----------------------------------------------------------------------------
module utc2ep_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [utc2ep_pkg::YrsW-1:0]       in_years_since_1900,
  input logic [utc2ep_pkg::MonW-1:0]       in_month_index,
  input logic [utc2ep_pkg::DayW-1:0]       in_day_of_month,
  input logic [utc2ep_pkg::HourW-1:0]      in_hour_of_day,
  input logic [utc2ep_pkg::MinW-1:0]       in_minute_of_hour,
  input logic [utc2ep_pkg::SecW-1:0]       in_second_of_minute,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [utc2ep_pkg::EpochW-1:0]     out_epoch_seconds
);

  // a stalled result stays offered unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_epoch_seconds))
    else $error("stalled result changed");

  // input backpressure comes only from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // no result right after reset is released
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // an idle input with a free output drains one stage per cycle, so idle
  // accepting cycles that flush every stage leave the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !in_stall ##1 !in_valid && !in_stall ##1
    !in_valid && !in_stall ##1 !in_valid && !in_stall ##1
    !in_valid && !in_stall ##1 !in_valid && !in_stall |=> !out_valid)
    else $error("result appeared without an item");

endmodule

bind utc_calendar_to_epoch_seconds_core utc2ep_checker u_utc2ep_checker (.*);
